>>> rtl/core/event_flag_group_waiters_unit_assert.svh
// ----------------------------------------------------------------------------
// Event flag group waiters: assertion macros
// Shared helpers that wrap clocked implication checks with a reset guard.
// ----------------------------------------------------------------------------
`ifndef EVENT_FLAG_GROUP_WAITERS_UNIT_ASSERT_SVH
`define EVENT_FLAG_GROUP_WAITERS_UNIT_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define EFGW_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("efgw check failed");

// Next-cycle implication, checked only while out of reset.
`define EFGW_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("efgw check failed");

`endif

>>> rtl/core/efgw_pkg.sv
// ----------------------------------------------------------------------------
// Event flag group waiters package
// Sizes, operation and result codes, and the command record that moves from
// the front end through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package efgw_pkg;

  // Table and task sizes.
  localparam int WAIT_SLOTS = 8;
  localparam int NUM_TASKS  = 16;
  localparam int SLOT_IW    = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;

  // Command queue depth.
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Operation codes.
  localparam logic [2:0] OP_SET       = 3'd0;
  localparam logic [2:0] OP_CLEAR     = 3'd1;
  localparam logic [2:0] OP_PEND      = 3'd2;
  localparam logic [2:0] OP_TIMEOUT   = 3'd3;
  localparam logic [2:0] OP_RESET     = 3'd4;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd5;
  localparam logic [2:0] OP_CHECK     = 3'd6;

  // Wait types.
  localparam logic [1:0] TYPE_ANY   = 2'd1;
  localparam logic [1:0] TYPE_EXACT = 2'd2;

  // Result codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_BAD_CMD = 2'd2;

  localparam logic KIND_DONE   = 1'b0;
  localparam logic KIND_WAKE   = 1'b1;
  localparam logic CAUSE_MATCH = 1'b0;
  localparam logic CAUSE_RESET = 1'b1;

  localparam logic [7:0] FLAGS_CLEARED = 8'h00;

  // Classified command.
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  mask;
    logic [3:0]  task_id;
    logic [31:0] timeout;
    logic        task_ok;
    logic        pend_ok;
    logic        exact;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/efgw_front.sv
// ----------------------------------------------------------------------------
// Event flag group waiters: front end
// Accepts items, classifies them and hands them to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module efgw_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [2:0]    in_op,
  input  wire logic [7:0]    in_mask,
  input  wire logic [3:0]    in_task_id,
  input  wire logic [1:0]    in_wait_type,
  input  wire logic [31:0]   in_timeout,
  input  wire logic          q_full,
  output logic               q_push,
  output efgw_pkg::cmd_t     q_cmd
);

  logic           hold_vld_r;
  efgw_pkg::cmd_t hold_cmd_r;
  efgw_pkg::cmd_t cls_cmd;
  logic           accept;

  // The holding stage frees up in the same cycle that it pushes.
  assign q_push = hold_vld_r && !q_full;
  assign busy   = hold_vld_r && q_full;
  assign accept = start && !busy;
  assign q_cmd  = hold_cmd_r;

  // Classify the item: check the task number and the wait type up front.
  always_comb begin
    cls_cmd.op      = in_op;
    cls_cmd.mask    = in_mask;
    cls_cmd.task_id = in_task_id;
    cls_cmd.timeout = in_timeout;
    cls_cmd.task_ok = (32'(in_task_id) < 32'(efgw_pkg::NUM_TASKS));
    cls_cmd.exact   = (in_wait_type == efgw_pkg::TYPE_EXACT);
    cls_cmd.pend_ok = cls_cmd.task_ok &&
                      ((in_wait_type == efgw_pkg::TYPE_ANY) ||
                       (in_wait_type == efgw_pkg::TYPE_EXACT));
  end

  // Holding stage valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (accept) begin
      hold_vld_r <= 1'b1;
    end else if (q_push) begin
      hold_vld_r <= 1'b0;
    end
  end

  // Holding stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd_r <= cls_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/efgw_queue.sv
// ----------------------------------------------------------------------------
// Event flag group waiters: command queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "event_flag_group_waiters_unit_assert.svh"

module efgw_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire efgw_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_vld,
  output efgw_pkg::cmd_t      head_cmd
);

  efgw_pkg::cmd_t                  store_r [efgw_pkg::Q_DEPTH];
  logic [efgw_pkg::Q_PW-1:0]       wr_ptr_r;
  logic [efgw_pkg::Q_PW-1:0]       rd_ptr_r;
  logic [efgw_pkg::Q_CW-1:0]       count_r;
  logic [efgw_pkg::Q_PW-1:0]       wr_ptr_nxt;
  logic [efgw_pkg::Q_PW-1:0]       rd_ptr_nxt;

  assign full     = (count_r == efgw_pkg::Q_CW'(efgw_pkg::Q_DEPTH));
  assign head_vld = (count_r != '0);
  assign head_cmd = store_r[rd_ptr_r];

  // Pointer wrap.
  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == efgw_pkg::Q_PW'(efgw_pkg::Q_DEPTH - 1)) ?
                 '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == efgw_pkg::Q_PW'(efgw_pkg::Q_DEPTH - 1)) ?
                 '0 : rd_ptr_r + 1'b1;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_cmd;
    end
  end

  // The front end never pushes into a full queue.
  `EFGW_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full)
  // The back end only pops a valid entry.
  `EFGW_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, head_vld)
  // A push without a pop grows the count by one.
  `EFGW_ASSERT_NEXT(a_count_grows, clk, rst_n, push && !pop,
                    count_r == $past(count_r) + 1'b1)

endmodule

`default_nettype wire

>>> rtl/core/efgw_back.sv
// ----------------------------------------------------------------------------
// Event flag group waiters: back end
// Holds the flag group and waiter slots, executes commands, scans the slots
// one per cycle after set, clear and reset, and emits wakes and completions.
// ----------------------------------------------------------------------------
`default_nettype none

`include "event_flag_group_waiters_unit_assert.svh"

module efgw_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           head_vld,
  input  wire efgw_pkg::cmd_t head_cmd,
  output logic                pop,
  output logic                out_strobe,
  output logic                out_kind,
  output logic [1:0]          out_status,
  output logic [7:0]          out_flag_value,
  output logic [3:0]          out_woken_task,
  output logic                out_wake_cause,
  output logic [31:0]         out_sleep_ticks,
  output logic                out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int SW = efgw_pkg::SLOT_IW;

  logic [1:0]    state_r, state_nxt;
  logic [7:0]    flags_r, flags_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic          scan_reset_r, scan_reset_nxt;
  logic [efgw_pkg::WAIT_SLOTS-1:0] slot_busy_r, slot_busy_nxt;
  logic [3:0]    slot_task_r  [efgw_pkg::WAIT_SLOTS];
  logic [7:0]    slot_mask_r  [efgw_pkg::WAIT_SLOTS];
  logic          slot_exact_r [efgw_pkg::WAIT_SLOTS];

  logic          free_found;
  logic [SW-1:0] free_idx;
  logic          pend_we;
  logic [7:0]    cur_mask;
  logic          hit;

  logic          res_vld;
  logic          res_kind;
  logic [1:0]    res_status;
  logic [7:0]    res_flag;
  logic [3:0]    res_task;
  logic          res_cause;
  logic [31:0]   res_ticks;
  logic          res_last;

  logic          out_strobe_r;
  logic          out_kind_r;
  logic [1:0]    out_status_r;
  logic [7:0]    out_flag_r;
  logic [3:0]    out_task_r;
  logic          out_cause_r;
  logic [31:0]   out_ticks_r;
  logic          out_last_r;

  assign pop = head_vld && (state_r == ST_IDLE);

  // First free slot, lowest index wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < efgw_pkg::WAIT_SLOTS; i++) begin
      if (!slot_busy_r[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // Match test for the slot under scan against the updated flags.
  always_comb begin
    cur_mask = slot_mask_r[idx_r] & flags_r;
    if (scan_reset_r) begin
      hit = 1'b1;
    end else if (slot_exact_r[idx_r]) begin
      hit = (cur_mask == flags_r);
    end else begin
      hit = (cur_mask != 8'h00);
    end
  end

  // Command execution and scan sequencing.
  always_comb begin
    state_nxt      = state_r;
    flags_nxt      = flags_r;
    idx_nxt        = idx_r;
    scan_reset_nxt = scan_reset_r;
    slot_busy_nxt  = slot_busy_r;
    pend_we        = 1'b0;
    res_vld        = 1'b0;
    res_kind       = efgw_pkg::KIND_DONE;
    res_status     = efgw_pkg::STAT_OK;
    res_flag       = flags_r;
    res_task       = 4'd0;
    res_cause      = efgw_pkg::CAUSE_MATCH;
    res_ticks      = 32'd0;
    res_last       = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (head_vld) begin
          unique case (head_cmd.op)
            efgw_pkg::OP_SET: begin
              flags_nxt      = flags_r | head_cmd.mask;
              idx_nxt        = '0;
              scan_reset_nxt = 1'b0;
              state_nxt      = ST_SCAN;
            end
            efgw_pkg::OP_CLEAR: begin
              flags_nxt      = flags_r & ~head_cmd.mask;
              idx_nxt        = '0;
              scan_reset_nxt = 1'b0;
              state_nxt      = ST_SCAN;
            end
            efgw_pkg::OP_RESET: begin
              flags_nxt      = efgw_pkg::FLAGS_CLEARED;
              idx_nxt        = '0;
              scan_reset_nxt = 1'b1;
              state_nxt      = ST_SCAN;
            end
            efgw_pkg::OP_PEND: begin
              res_vld  = 1'b1;
              res_task = head_cmd.task_id;
              if (head_cmd.pend_ok && free_found) begin
                pend_we                 = 1'b1;
                slot_busy_nxt[free_idx] = 1'b1;
                res_ticks               = head_cmd.timeout;
              end else begin
                res_status = efgw_pkg::STAT_FULL;
              end
            end
            efgw_pkg::OP_TIMEOUT: begin
              res_vld = 1'b1;
              for (int i = 0; i < efgw_pkg::WAIT_SLOTS; i++) begin
                if (head_cmd.task_ok && slot_busy_r[i] &&
                    (slot_task_r[i] == head_cmd.task_id)) begin
                  slot_busy_nxt[i] = 1'b0;
                end
              end
            end
            efgw_pkg::OP_CLEAR_ALL: begin
              flags_nxt = efgw_pkg::FLAGS_CLEARED;
              res_vld   = 1'b1;
              res_flag  = efgw_pkg::FLAGS_CLEARED;
            end
            efgw_pkg::OP_CHECK: begin
              res_vld = 1'b1;
            end
            default: begin
              res_vld    = 1'b1;
              res_status = efgw_pkg::STAT_BAD_CMD;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (slot_busy_r[idx_r] && hit) begin
          res_vld              = 1'b1;
          res_kind             = efgw_pkg::KIND_WAKE;
          res_task             = slot_task_r[idx_r];
          res_cause            = scan_reset_r ? efgw_pkg::CAUSE_RESET :
                                                efgw_pkg::CAUSE_MATCH;
          res_last             = 1'b0;
          slot_busy_nxt[idx_r] = 1'b0;
        end
        if (idx_r == SW'(efgw_pkg::WAIT_SLOTS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        res_vld   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      flags_r      <= efgw_pkg::FLAGS_CLEARED;
      slot_busy_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flags_r      <= flags_nxt;
      slot_busy_r  <= slot_busy_nxt;
      out_strobe_r <= res_vld;
    end
  end

  // Scan position and result payload.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    scan_reset_r <= scan_reset_nxt;
    out_kind_r   <= res_kind;
    out_status_r <= res_status;
    out_flag_r   <= res_flag;
    out_task_r   <= res_task;
    out_cause_r  <= res_cause;
    out_ticks_r  <= res_ticks;
    out_last_r   <= res_last;
  end

  // Slot contents are written on a successful pend.
  always_ff @(posedge clk) begin
    if (pend_we) begin
      slot_task_r[free_idx]  <= head_cmd.task_id;
      slot_mask_r[free_idx]  <= head_cmd.mask;
      slot_exact_r[free_idx] <= head_cmd.exact;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_flag_value  = out_flag_r;
  assign out_woken_task  = out_task_r;
  assign out_wake_cause  = out_cause_r;
  assign out_sleep_ticks = out_ticks_r;
  assign out_last        = out_last_r;

  // A wake notice is never the final result of an item.
  `EFGW_ASSERT_NOW(a_wake_not_last, clk, rst_n,
                   out_strobe_r && (out_kind_r == efgw_pkg::KIND_WAKE), !out_last_r)
  // Once the final result shows, the back end is ready for the next command.
  `EFGW_ASSERT_NOW(a_last_idle, clk, rst_n, out_strobe_r && out_last_r,
                   state_r == ST_IDLE)
  // Error statuses only appear on completions.
  `EFGW_ASSERT_NOW(a_status_on_done, clk, rst_n,
                   out_strobe_r && (out_status_r != efgw_pkg::STAT_OK),
                   out_kind_r == efgw_pkg::KIND_DONE)
  // A scan always ends in the completion step.
  `EFGW_ASSERT_NEXT(a_scan_ends, clk, rst_n,
                    (state_r == ST_SCAN) && (idx_r == SW'(efgw_pkg::WAIT_SLOTS - 1)),
                    state_r == ST_DONE)

endmodule

`default_nettype wire

>>> rtl/core/event_flag_group_waiters_unit.sv
// ----------------------------------------------------------------------------
// Event flag group waiters unit
// One 8-bit flag group with a table of waiter slots; a front end classifies
// items, a short queue decouples it from the back end that executes them.
//
//   Channel   Handshake            Ports
//   input     start && !busy       in_op, in_mask, in_task_id, in_wait_type,
//                                  in_timeout
//   result    out_strobe (1 cyc)   out_kind, out_status, out_flag_value,
//                                  out_woken_task, out_wake_cause,
//                                  out_sleep_ticks, out_last
//
// Set, clear and reset hold the back end through a load step, a scan step per
// slot and a completion step; other ops finish in the load step alone. The
// slot scan sets the rate. An item passes the holding stage, a queue entry
// and the back end's registered outputs before its completion shows.
// Reset is synchronous and active low; it clears the flags and all slots.
// Results cannot be stalled; busy rises only while the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module event_flag_group_waiters_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [7:0]  in_mask,
  input  wire logic [3:0]  in_task_id,
  input  wire logic [1:0]  in_wait_type,
  input  wire logic [31:0] in_timeout,
  output logic             out_strobe,
  output logic             out_kind,
  output logic [1:0]       out_status,
  output logic [7:0]       out_flag_value,
  output logic [3:0]       out_woken_task,
  output logic             out_wake_cause,
  output logic [31:0]      out_sleep_ticks,
  output logic             out_last
);

  logic           q_full;
  logic           q_push;
  efgw_pkg::cmd_t q_in_cmd;
  logic           q_pop;
  logic           q_head_vld;
  efgw_pkg::cmd_t q_head_cmd;

  // Front end: accept and classify.
  efgw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_mask      (in_mask),
    .in_task_id   (in_task_id),
    .in_wait_type (in_wait_type),
    .in_timeout   (in_timeout),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_in_cmd)
  );

  // Command queue.
  efgw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_vld (q_head_vld),
    .head_cmd (q_head_cmd)
  );

  // Back end: flag group, slots and results.
  efgw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_vld        (q_head_vld),
    .head_cmd        (q_head_cmd),
    .pop             (q_pop),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_flag_value  (out_flag_value),
    .out_woken_task  (out_woken_task),
    .out_wake_cause  (out_wake_cause),
    .out_sleep_ticks (out_sleep_ticks),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

>>> sim/tb_event_flag_group_waiters_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the event flag group waiters unit
// Drives set, clear, pend, timeout, reset, clear-all, check and invalid
// items through the start/busy handshake. A shadow copy of the flag group
// and the waiter table predicts every wake notice and completion. Each
// strobed result is compared against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_event_flag_group_waiters_unit;

  // Codes that the package does not name.
  localparam logic [2:0] OP_INVALID = 3'd7;
  localparam logic [1:0] TYPE_RSVD0 = 2'd0;
  localparam logic [1:0] TYPE_RSVD3 = 2'd3;

  localparam int IDLE_LIMIT    = 1000;
  localparam int TAIL_CYCLES   = 2 * (efgw_pkg::WAIT_SLOTS + 2) + 4;
  localparam int RANDOM_ITEMS  = 500;
  localparam int SHOWN_ERRORS  = 10;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  mask;
    logic [3:0]  task_id;
    logic [1:0]  wait_type;
    logic [31:0] timeout;
  } flag_cmd_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  flag_value;
    logic [3:0]  woken_task;
    logic        wake_cause;
    logic [31:0] sleep_ticks;
    logic        last;
  } notice_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_op = '0;
  logic [7:0]  in_mask = '0;
  logic [3:0]  in_task_id = '0;
  logic [1:0]  in_wait_type = '0;
  logic [31:0] in_timeout = '0;
  logic        out_strobe;
  logic        out_kind;
  logic [1:0]  out_status;
  logic [7:0]  out_flag_value;
  logic [3:0]  out_woken_task;
  logic        out_wake_cause;
  logic [31:0] out_sleep_ticks;
  logic        out_last;

  // Shadow flag group and waiter table.
  logic [7:0]  grp_flags;
  logic        slot_used     [efgw_pkg::WAIT_SLOTS];
  logic [3:0]  slot_owner    [efgw_pkg::WAIT_SLOTS];
  logic [7:0]  slot_bits     [efgw_pkg::WAIT_SLOTS];
  logic        slot_is_exact [efgw_pkg::WAIT_SLOTS];

  // Predicted wake notices and completions, oldest first.
  notice_t notice_q[$];

  int      mismatch_count = 0;
  bit      calm = 1'b0;
  notice_t got_notice;
  notice_t want_notice;

  event_flag_group_waiters_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_mask        (in_mask),
    .in_task_id     (in_task_id),
    .in_wait_type   (in_wait_type),
    .in_timeout     (in_timeout),
    .out_strobe     (out_strobe),
    .out_kind       (out_kind),
    .out_status     (out_status),
    .out_flag_value (out_flag_value),
    .out_woken_task (out_woken_task),
    .out_wake_cause (out_wake_cause),
    .out_sleep_ticks(out_sleep_ticks),
    .out_last       (out_last)
  );

  always #10 clk = ~clk;

  function automatic flag_cmd_t cmd(input logic [2:0] op, input logic [7:0] mask,
                                    input logic [3:0] tid, input logic [1:0] wt,
                                    input logic [31:0] tmo);
    flag_cmd_t c;
    c.op = op;
    c.mask = mask;
    c.task_id = tid;
    c.wait_type = wt;
    c.timeout = tmo;
    return c;
  endfunction

  function automatic string fmt_notice(input notice_t n);
    return $sformatf("kind=%0d status=%0d flags=%02h task=%0d cause=%0d ticks=%08h last=%0d",
                     n.kind, n.status, n.flag_value, n.woken_task, n.wake_cause,
                     n.sleep_ticks, n.last);
  endfunction

  task automatic push_notice(input logic kind, input logic [1:0] status,
                             input logic [7:0] fv, input logic [3:0] tid,
                             input logic cause, input logic [31:0] ticks,
                             input logic last);
    notice_t n;
    n.kind = kind;
    n.status = status;
    n.flag_value = fv;
    n.woken_task = tid;
    n.wake_cause = cause;
    n.sleep_ticks = ticks;
    n.last = last;
    notice_q.push_back(n);
  endtask

  task automatic clear_flag_group();
    grp_flags = efgw_pkg::FLAGS_CLEARED;
    for (int i = 0; i < efgw_pkg::WAIT_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_owner[i] = '0;
      slot_bits[i] = '0;
      slot_is_exact[i] = 1'b0;
    end
  endtask

  // Applies one accepted item to the shadow group and queues its results.
  task automatic step_flag_group(input flag_cmd_t c);
    logic hit;
    logic placed;
    placed = 1'b0;
    case (c.op)
      efgw_pkg::OP_SET, efgw_pkg::OP_CLEAR: begin
        if (c.op == efgw_pkg::OP_SET) grp_flags = grp_flags | c.mask;
        else grp_flags = grp_flags & ~c.mask;
        // Scan the slots in order against the updated flags.
        for (int i = 0; i < efgw_pkg::WAIT_SLOTS; i++) begin
          if (slot_used[i]) begin
            if (slot_is_exact[i]) hit = ((slot_bits[i] & grp_flags) == grp_flags);
            else hit = ((slot_bits[i] & grp_flags) != 8'h00);
            if (hit) begin
              push_notice(efgw_pkg::KIND_WAKE, efgw_pkg::STAT_OK, grp_flags,
                          slot_owner[i], efgw_pkg::CAUSE_MATCH, 32'd0, 1'b0);
              slot_used[i] = 1'b0;
            end
          end
        end
        push_notice(efgw_pkg::KIND_DONE, efgw_pkg::STAT_OK, grp_flags, 4'd0,
                    efgw_pkg::CAUSE_MATCH, 32'd0, 1'b1);
      end
      efgw_pkg::OP_PEND: begin
        if ((c.wait_type == efgw_pkg::TYPE_ANY || c.wait_type == efgw_pkg::TYPE_EXACT) &&
            (int'(c.task_id) < efgw_pkg::NUM_TASKS)) begin
          for (int i = 0; i < efgw_pkg::WAIT_SLOTS; i++) begin
            if (!placed && !slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_owner[i] = c.task_id;
              slot_bits[i] = c.mask;
              slot_is_exact[i] = (c.wait_type == efgw_pkg::TYPE_EXACT);
              placed = 1'b1;
            end
          end
        end
        push_notice(efgw_pkg::KIND_DONE, placed ? efgw_pkg::STAT_OK : efgw_pkg::STAT_FULL,
                    grp_flags, c.task_id, efgw_pkg::CAUSE_MATCH,
                    placed ? c.timeout : 32'd0, 1'b1);
      end
      efgw_pkg::OP_TIMEOUT: begin
        if (int'(c.task_id) < efgw_pkg::NUM_TASKS) begin
          for (int i = 0; i < efgw_pkg::WAIT_SLOTS; i++)
            if (slot_used[i] && slot_owner[i] == c.task_id) slot_used[i] = 1'b0;
        end
        push_notice(efgw_pkg::KIND_DONE, efgw_pkg::STAT_OK, grp_flags, 4'd0,
                    efgw_pkg::CAUSE_MATCH, 32'd0, 1'b1);
      end
      efgw_pkg::OP_RESET: begin
        grp_flags = efgw_pkg::FLAGS_CLEARED;
        for (int i = 0; i < efgw_pkg::WAIT_SLOTS; i++) begin
          if (slot_used[i]) begin
            push_notice(efgw_pkg::KIND_WAKE, efgw_pkg::STAT_OK, efgw_pkg::FLAGS_CLEARED,
                        slot_owner[i], efgw_pkg::CAUSE_RESET, 32'd0, 1'b0);
            slot_used[i] = 1'b0;
          end
        end
        push_notice(efgw_pkg::KIND_DONE, efgw_pkg::STAT_OK, grp_flags, 4'd0,
                    efgw_pkg::CAUSE_MATCH, 32'd0, 1'b1);
      end
      efgw_pkg::OP_CLEAR_ALL: begin
        grp_flags = efgw_pkg::FLAGS_CLEARED;
        push_notice(efgw_pkg::KIND_DONE, efgw_pkg::STAT_OK, grp_flags, 4'd0,
                    efgw_pkg::CAUSE_MATCH, 32'd0, 1'b1);
      end
      efgw_pkg::OP_CHECK: begin
        push_notice(efgw_pkg::KIND_DONE, efgw_pkg::STAT_OK, grp_flags, 4'd0,
                    efgw_pkg::CAUSE_MATCH, 32'd0, 1'b1);
      end
      default: begin
        push_notice(efgw_pkg::KIND_DONE, efgw_pkg::STAT_BAD_CMD, grp_flags, 4'd0,
                    efgw_pkg::CAUSE_MATCH, 32'd0, 1'b1);
      end
    endcase
  endtask

  // Sends one item; the caller stands at a rising edge. Start stays high
  // after acceptance so that a back-to-back item follows with no gap.
  task automatic send_cmd(input flag_cmd_t c);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_op        <= c.op;
    in_mask      <= c.mask;
    in_task_id   <= c.task_id;
    in_wait_type <= c.wait_type;
    in_timeout   <= c.timeout;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    step_flag_group(c);
  endtask

  // Holds the sender off until every predicted result has arrived.
  task automatic wait_all_results();
    start <= 1'b0;
    while (notice_q.size() != 0) @(posedge clk);
  endtask

  // Invalid command, check and clear-all on an empty group.
  task automatic test_plain_ops();
    send_cmd(cmd(OP_INVALID, 8'hFF, 4'hF, TYPE_RSVD3, 32'hFFFF_FFFF));
    send_cmd(cmd(efgw_pkg::OP_CHECK, 8'h00, 4'h0, TYPE_RSVD0, 32'h0));
    send_cmd(cmd(efgw_pkg::OP_CLEAR_ALL, 8'h5A, 4'h3, efgw_pkg::TYPE_ANY, 32'h0));
  endtask

  // Set and clear with the extreme masks.
  task automatic test_flag_extremes();
    send_cmd(cmd(efgw_pkg::OP_SET, 8'hFF, 4'h0, TYPE_RSVD0, 32'h0));
    send_cmd(cmd(efgw_pkg::OP_CLEAR, 8'h00, 4'h0, TYPE_RSVD0, 32'h0));
    send_cmd(cmd(efgw_pkg::OP_CLEAR, 8'hFF, 4'h0, TYPE_RSVD0, 32'h0));
    send_cmd(cmd(efgw_pkg::OP_SET, 8'h00, 4'h0, TYPE_RSVD0, 32'h0));
  endtask

  // Pends with a rejected wait type take no slot.
  task automatic test_bad_wait_type();
    send_cmd(cmd(efgw_pkg::OP_PEND, 8'hFF, 4'h7, TYPE_RSVD0, 32'h1234_5678));
    send_cmd(cmd(efgw_pkg::OP_PEND, 8'h01, 4'h8, TYPE_RSVD3, 32'hFFFF_FFFF));
  endtask

  // Fill every slot, overflow once, then reset wakes the whole table.
  task automatic test_full_table_and_reset();
    for (int i = 0; i < efgw_pkg::WAIT_SLOTS; i++)
      send_cmd(cmd(efgw_pkg::OP_PEND,
                   (i == 0) ? 8'h00 : ((i == 1) ? 8'hFF : 8'(1 << i)),
                   (i == 0) ? 4'h0 : ((i == 1) ? 4'hF : 4'(i)),
                   i[0] ? efgw_pkg::TYPE_EXACT : efgw_pkg::TYPE_ANY,
                   (i == 0) ? 32'h0 : ((i == 1) ? 32'hFFFF_FFFF : 32'(i * 100))));
    send_cmd(cmd(efgw_pkg::OP_PEND, 8'hAA, 4'h9, efgw_pkg::TYPE_ANY, 32'h55));
    send_cmd(cmd(efgw_pkg::OP_RESET, 8'h00, 4'h0, TYPE_RSVD0, 32'h0));
  endtask

  // A pend does not test the current flags; a later scan wakes the waiter.
  task automatic test_pend_against_flags();
    send_cmd(cmd(efgw_pkg::OP_SET, 8'h01, 4'h0, TYPE_RSVD0, 32'h0));
    send_cmd(cmd(efgw_pkg::OP_PEND, 8'h01, 4'h3, efgw_pkg::TYPE_ANY, 32'h10));
    send_cmd(cmd(efgw_pkg::OP_SET, 8'h00, 4'h0, TYPE_RSVD0, 32'h0));
  endtask

  // Empty flags wake every exact waiter but no any waiter; timeout frees the rest.
  task automatic test_exact_on_empty_and_timeout();
    send_cmd(cmd(efgw_pkg::OP_PEND, 8'h0F, 4'h9, efgw_pkg::TYPE_EXACT, 32'h0));
    send_cmd(cmd(efgw_pkg::OP_PEND, 8'hFF, 4'hA, efgw_pkg::TYPE_ANY, 32'h0));
    send_cmd(cmd(efgw_pkg::OP_CLEAR, 8'hFF, 4'h0, TYPE_RSVD0, 32'h0));
    send_cmd(cmd(efgw_pkg::OP_TIMEOUT, 8'h00, 4'hA, TYPE_RSVD0, 32'h0));
  endtask

  // Weighted random traffic with random content and a little noise.
  task automatic test_random_mix();
    flag_cmd_t c;
    int        sel;
    int        pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) wait_all_results();
      c.op = efgw_pkg::OP_CHECK;
      c.mask = 8'($urandom);
      c.task_id = 4'($urandom);
      c.wait_type = 2'($urandom);
      c.timeout = $urandom;
      case ($urandom_range(0, 3))
        0: c.mask = 8'(1 << $urandom_range(0, 7));
        1: c.mask = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: ;
      endcase
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        c.op = efgw_pkg::OP_PEND;
        if ($urandom_range(0, 9) != 0)
          c.wait_type = $urandom_range(0, 1) ? efgw_pkg::TYPE_ANY : efgw_pkg::TYPE_EXACT;
        pick = $urandom_range(0, 9);
        if (pick < 2) c.timeout = 32'h0;
        else if (pick == 2) c.timeout = 32'hFFFF_FFFF;
      end else if (sel < 55) begin
        c.op = efgw_pkg::OP_SET;
      end else if (sel < 75) begin
        c.op = efgw_pkg::OP_CLEAR;
      end else if (sel < 83) begin
        c.op = efgw_pkg::OP_TIMEOUT;
        // Usually aim at a task that is actually waiting.
        pick = $urandom_range(0, efgw_pkg::WAIT_SLOTS - 1);
        if (slot_used[pick] && $urandom_range(0, 3) != 0) c.task_id = slot_owner[pick];
      end else if (sel < 87) begin
        c.op = efgw_pkg::OP_RESET;
      end else if (sel < 92) begin
        c.op = efgw_pkg::OP_CLEAR_ALL;
      end else if (sel < 96) begin
        c.op = efgw_pkg::OP_CHECK;
      end else begin
        c.op = OP_INVALID;
      end
      send_cmd(c);
    end
  endtask

  // Compare each strobed result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      got_notice = {out_kind, out_status, out_flag_value, out_woken_task,
                    out_wake_cause, out_sleep_ticks, out_last};
      if (notice_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
          $display("unexpected result: %s", fmt_notice(got_notice));
      end else begin
        want_notice = notice_q.pop_front();
        if (got_notice !== want_notice) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_ERRORS)
            $display("mismatch: expected %s, actual %s", fmt_notice(want_notice),
                     fmt_notice(got_notice));
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no item or result moving.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_strobe) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    clear_flag_group();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_ops();
    test_flag_extremes();
    test_bad_wait_type();
    test_full_table_and_reset();
    test_pend_against_flags();
    test_exact_on_empty_and_timeout();
    test_random_mix();

    // Drain, then give the block time to show any stray result.
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && notice_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
